// ----- rtl/imt_pkg.sv -----
// ----------------------------------------------------------------------------
// imt_pkg
// Shared types and constants for the indexed array with min tree.
// ----------------------------------------------------------------------------
package imt_pkg;

	localparam int ENTRIES_DEFAULT = 1024;
	// widest store address over the full parameter range (65536 entries + 1)
	localparam int ADDR_W = 17;
	localparam int INDEX_W = 11;
	localparam int DATA_W = 32;

	localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef struct packed {
		logic kind;
		logic [INDEX_W-1:0] cell_index;
		logic signed [DATA_W-1:0] write_value;
	} cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		logic signed [DATA_W-1:0] min_value;
		logic bad_index;
	} result_t;

	typedef struct packed {
		logic cell_we;
		addr_t cell_waddr;
		data_t cell_wdata;
		addr_t cell_raddr;
		logic tree_we;
		addr_t tree_waddr;
		data_t tree_wdata;
		addr_t tree_raddr_a;
		addr_t tree_raddr_b;
	} mem_req_t;

	typedef struct packed {
		data_t cell_rd;
		data_t tree_rd_a;
		data_t tree_rd_b;
	} mem_rsp_t;

endpackage

// ----- rtl/indexed_array_min_tree.sv -----
// ----------------------------------------------------------------------------
// indexed_array_min_tree
// Array of signed cells with a heap-ordered min tree; reports the global min.
// ----------------------------------------------------------------------------
// Answers: a bad index strobes in the cycle after start, a read goes via ST_RDOUT,
//   a write walks up from its node at depth d = floor(log2(index)) to the root.
// The write walk does one tree level per cycle through the shared min unit.
// Throughput: busy stays high until the word is done; the next start may
//   follow in the cycle the result strobe shows. The receiver cannot stall.
// Reset: after arst_n releases, a clearing pass fills both memories with INT_MAX,
//   during which busy is high.
// ----------------------------------------------------------------------------
module indexed_array_min_tree #(
	parameter int ENTRIES = imt_pkg::ENTRIES_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  imt_pkg::cmd_t    cmd,
	output logic             strobe,
	output imt_pkg::result_t result
);
	import imt_pkg::*;

	localparam int AW = $clog2(ENTRIES + 1);
	localparam int CW = AW + 1;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_RDOUT = 3'd2;
	localparam logic [2:0] ST_LEAF  = 3'd3;
	localparam logic [2:0] ST_WALK  = 3'd4;

	logic [2:0]    state_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] cur_q;
	data_t         val_q;
	data_t         curval_q;
	data_t         root_q;
	logic          x_ok_q;
	logic          y_ok_q;
	logic          strobe_q;
	result_t       result_q;

	mem_req_t req;
	mem_rsp_t rsp;

	logic          accept;
	logic          in_ok;
	logic [AW-1:0] idx;
	logic [CW-1:0] child_a;
	logic [CW-1:0] child_b;
	logic [AW-1:0] parent;
	logic [CW-1:0] sib;
	data_t         mu_own;
	data_t         mu_x;
	data_t         mu_m;

	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign strobe = strobe_q;
	assign result = result_q;

	assign in_ok = (cmd.cell_index != '0) && (32'(cmd.cell_index) <= 32'(ENTRIES));
	assign idx = AW'(cmd.cell_index);
	assign child_a = {idx, 1'b0};
	assign child_b = {idx, 1'b1};
	assign parent = cur_q >> 1;
	assign sib = {1'b0, cur_q} ^ CW'(1);

	assign mu_own = (state_q == ST_LEAF) ? val_q : rsp.cell_rd;
	assign mu_x = (state_q == ST_LEAF) ? rsp.tree_rd_a : curval_q;

	imt_min_unit u_min (
		.own  (mu_own),
		.x    (mu_x),
		.x_ok (x_ok_q),
		.y    (rsp.tree_rd_b),
		.y_ok (y_ok_q),
		.m    (mu_m)
	);

	imt_store #(
		.ENTRIES (ENTRIES)
	) u_store (
		.clk (clk),
		.req (req),
		.rsp (rsp)
	);

	always_comb begin
		req = '0;
		case (state_q)
			ST_CLEAR: begin
				req.cell_we = 1'b1;
				req.cell_waddr = ADDR_W'(clr_q);
				req.cell_wdata = INT_MAX;
				req.tree_we = 1'b1;
				req.tree_waddr = ADDR_W'(clr_q);
				req.tree_wdata = INT_MAX;
			end
			ST_IDLE: begin
				if (accept && in_ok) begin
					req.cell_raddr = ADDR_W'(idx);
					if (cmd.kind == KIND_WRITE) begin
						req.cell_we = 1'b1;
						req.cell_waddr = ADDR_W'(idx);
						req.cell_wdata = cmd.write_value;
						req.tree_raddr_a = ADDR_W'(child_a);
						req.tree_raddr_b = ADDR_W'(child_b);
					end
				end
			end
			ST_LEAF, ST_WALK: begin
				req.tree_we = 1'b1;
				req.tree_waddr = ADDR_W'(cur_q);
				req.tree_wdata = mu_m;
				// fetch the parent's cell and this node's sibling for the next level
				req.cell_raddr = ADDR_W'(parent);
				req.tree_raddr_b = ADDR_W'(sib);
			end
			default: begin
				req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			root_q <= INT_MAX;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					if (clr_q == AW'(ENTRIES)) begin
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (!in_ok) begin
							strobe_q <= 1'b1;
						end else if (cmd.kind == KIND_READ) begin
							state_q <= ST_RDOUT;
						end else begin
							state_q <= ST_LEAF;
						end
					end
				end
				ST_RDOUT: begin
					strobe_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_LEAF, ST_WALK: begin
					if (cur_q == AW'(1)) begin
						root_q <= mu_m;
						strobe_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_WALK;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cur_q <= idx;
					val_q <= cmd.write_value;
					x_ok_q <= (child_a <= CW'(ENTRIES));
					y_ok_q <= (child_b <= CW'(ENTRIES));
					if (!in_ok) begin
						result_q.read_value <= '0;
						result_q.min_value <= root_q;
						result_q.bad_index <= 1'b1;
					end
				end
			end
			ST_RDOUT: begin
				result_q.read_value <= rsp.cell_rd;
				result_q.min_value <= root_q;
				result_q.bad_index <= 1'b0;
			end
			ST_LEAF, ST_WALK: begin
				curval_q <= mu_m;
				cur_q <= parent;
				x_ok_q <= 1'b1;
				y_ok_q <= (sib <= CW'(ENTRIES));
				result_q.read_value <= val_q;
				result_q.min_value <= mu_m;
				result_q.bad_index <= 1'b0;
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_bad_fast: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !in_ok |=> strobe && result.bad_index)
		else $error("bad index word not answered next cycle");

	a_read_lat: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_ok && (cmd.kind == KIND_READ) |=> ##1 strobe)
		else $error("read word not answered after two cycles");

	a_min_le_cell: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.bad_index |-> result.min_value <= result.read_value)
		else $error("reported minimum exceeds the cell value");

	a_walk_cur: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> cur_q != '0)
		else $error("tree walk went past the root");
`endif

endmodule

// ----- rtl/imt_min_unit.sv -----
// ----------------------------------------------------------------------------
// imt_min_unit
// Shared minimum unit: node value from own cell and up to two tree values.
// ----------------------------------------------------------------------------
module imt_min_unit (
	input  imt_pkg::data_t own,
	input  imt_pkg::data_t x,
	input  logic           x_ok,
	input  imt_pkg::data_t y,
	input  logic           y_ok,
	output imt_pkg::data_t m
);
	import imt_pkg::*;

	data_t m1;

	always_comb begin
		m1 = (x_ok && (x < own)) ? x : own;
		m = (y_ok && (y < m1)) ? y : m1;
	end

endmodule

// ----- rtl/imt_store.sv -----
// ----------------------------------------------------------------------------
// imt_store
// Cell memory (one read port) and tree memory (two read ports), both with
// one write port and registered read data.
// ----------------------------------------------------------------------------
module imt_store #(
	parameter int ENTRIES = imt_pkg::ENTRIES_DEFAULT
) (
	input  logic              clk,
	input  imt_pkg::mem_req_t req,
	output imt_pkg::mem_rsp_t rsp
);
	import imt_pkg::*;

	localparam int AW = $clog2(ENTRIES + 1);

	// entry 0 is unused; cells and nodes are numbered from 1
	data_t cell_mem [0:ENTRIES];
	data_t tree_mem [0:ENTRIES];

	always_ff @(posedge clk) begin
		if (req.cell_we) begin
			cell_mem[AW'(req.cell_waddr)] <= req.cell_wdata;
		end
		rsp.cell_rd <= cell_mem[AW'(req.cell_raddr)];
		if (req.tree_we) begin
			tree_mem[AW'(req.tree_waddr)] <= req.tree_wdata;
		end
		rsp.tree_rd_a <= tree_mem[AW'(req.tree_raddr_a)];
		rsp.tree_rd_b <= tree_mem[AW'(req.tree_raddr_b)];
	end

endmodule
